FILE: design/sfc_pkg.sv
// Shared types, constants and the CRC-8 update function for the SPI frame checker.
package sfc_pkg;

  // Input beat kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Frame check constants
  localparam logic [7:0] HEADER_VALUE  = 8'hDE;
  localparam logic [7:0] CRC_POLY_REFL = 8'h18;
  localparam logic [7:0] CRC_INIT      = 8'hFF;
  localparam logic [7:0] CRC_TOP_BIT   = 8'h80;
  localparam logic [7:0] MIN_FRAME     = 8'd3;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_HDR = 2'd1;
  localparam logic [1:0] STATUS_BAD_CRC = 2'd2;

  // One input item handed from the input register to the frame core
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } sfc_item_t;

  // One result item
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] first_byte;
    logic [7:0] command;
    logic [7:0] arg_one;
    logic [7:0] arg_two;
    logic [7:0] frame_length;
  } sfc_result_t;

  // Reflected Maxim CRC-8, one byte, LSB first (eight unrolled bit steps)
  function automatic logic [7:0] crc8_update(input logic [7:0] value, input logic [7:0] crc);
    logic [7:0] c;
    logic [7:0] v;
    c = crc;
    v = value;
    for (int i = 0; i < 8; i++) begin
      if ((c[0] ^ v[0]) == 1'b1) begin
        c = ((c ^ CRC_POLY_REFL) >> 1) | CRC_TOP_BIT;
      end else begin
        c = c >> 1;
      end
      v = v >> 1;
    end
    return c;
  endfunction

endpackage

FILE: design/sfc_in_if.sv
// Input channel: received SPI bytes and select-release events.
interface sfc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

FILE: design/sfc_out_if.sv
// Result channel: one frame check verdict per finished non-empty frame.
interface sfc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] first_byte;
  logic [7:0] command;
  logic [7:0] arg_one;
  logic [7:0] arg_two;
  logic [7:0] frame_length;

  modport source (output valid, output status, output first_byte, output command,
                  output arg_one, output arg_two, output frame_length, input ready);
  modport sink   (input valid, input status, input first_byte, input command,
                  input arg_one, input arg_two, input frame_length, output ready);
endinterface

FILE: design/spi_frame_crc8_checker.sv
// Top level of the SPI command frame checker with reflected Maxim CRC-8.
//
// Usage:
//   in_ch carries one beat per received SPI byte (kind = data) or per
//   select release (kind = release). out_ch carries one verdict per
//   finished non-empty frame: status, the first four bytes (zero where
//   absent) and the frame length.
//   A frame ends on select release, or on the byte that brings it to
//   FRAME_BUFFER_BYTES-1 bytes; a release with no bytes gives no result.
// Timing:
//   A beat lands in an input register, then the frame core updates the
//   count and CRC (one unrolled byte step) and fills the result register.
//   A result is offered from the result register once that register is free to take it.
//   One beat per cycle is accepted as long as out_ch drains.
// Stall:
//   While a result waits in the output register and out_ch.ready is low,
//   an empty input register still takes one more beat, then in_ch.ready drops.
// Reset:
//   rst_n (synchronous, active low) empties both registers and starts a
//   fresh frame with the CRC at 0xFF.
module spi_frame_crc8_checker #(
  parameter int FRAME_BUFFER_BYTES = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  sfc_in_if.sink        in_ch,
  sfc_out_if.source     out_ch
);

  logic                 in_valid_r;
  sfc_pkg::sfc_item_t   in_item_r;
  logic                 out_valid_r, out_valid_nxt;
  sfc_pkg::sfc_result_t out_res_r;
  logic                 advance;
  logic                 step;
  logic                 res_valid;
  sfc_pkg::sfc_result_t res;

  // Pipeline flow: the input register moves on when the result slot frees up
  assign advance     = !out_valid_r || out_ch.ready;
  assign step        = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_r.kind      <= in_ch.kind;
      in_item_r.data_byte <= in_ch.data_byte;
    end
  end

  sfc_frame_core #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .item     (in_item_r),
    .res_valid(res_valid),
    .res      (res)
  );

  // Result register
  assign out_valid_nxt = advance ? res_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.first_byte   = out_res_r.first_byte;
  assign out_ch.command      = out_res_r.command;
  assign out_ch.arg_one      = out_res_r.arg_one;
  assign out_ch.arg_two      = out_res_r.arg_two;
  assign out_ch.frame_length = out_res_r.frame_length;

endmodule

FILE: design/sfc_frame_core.sv
// Frame state, running CRC and the end-of-frame verdict for one beat per cycle while step is high.
module sfc_frame_core #(
  parameter int FRAME_BUFFER_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  sfc_pkg::sfc_item_t  item,
  output logic                res_valid,
  output sfc_pkg::sfc_result_t res
);

  localparam logic [7:0] LAST_COUNT = 8'(FRAME_BUFFER_BYTES - 1);

  logic [7:0] byte_count_r, byte_count_nxt;
  logic [7:0] crc_running_r, crc_running_nxt;
  logic [7:0] crc_before_last_r, crc_before_last_nxt;
  logic [7:0] last_byte_r, last_byte_nxt;
  logic [7:0] header_r, header_nxt;
  logic [7:0] command_r, command_nxt;
  logic [7:0] arg_one_r, arg_one_nxt;
  logic [7:0] arg_two_r, arg_two_nxt;
  logic [7:0] count_seen;
  logic [7:0] crc_base;
  logic       is_data;
  logic       finish;

  assign is_data = step && (item.kind == sfc_pkg::KIND_DATA);

  // State after taking this beat (data bytes only)
  always_comb begin
    header_nxt          = header_r;
    command_nxt         = command_r;
    arg_one_nxt         = arg_one_r;
    arg_two_nxt         = arg_two_r;
    crc_running_nxt     = crc_running_r;
    crc_before_last_nxt = crc_before_last_r;
    last_byte_nxt       = last_byte_r;
    count_seen          = byte_count_r;
    crc_base            = (byte_count_r == 8'd0) ? sfc_pkg::CRC_INIT : crc_running_r;
    if (is_data) begin
      case (byte_count_r)
        8'd0: begin
          header_nxt  = item.data_byte;
          command_nxt = 8'd0;
          arg_one_nxt = 8'd0;
          arg_two_nxt = 8'd0;
        end
        8'd1: command_nxt = item.data_byte;
        8'd2: arg_one_nxt = item.data_byte;
        8'd3: arg_two_nxt = item.data_byte;
        default: ;
      endcase
      crc_before_last_nxt = crc_base;
      crc_running_nxt     = sfc_pkg::crc8_update(item.data_byte, crc_base);
      last_byte_nxt       = item.data_byte;
      count_seen          = byte_count_r + 8'd1;
    end
  end

  // Frame ends on select release with bytes pending, or when the buffer fills
  assign finish = step && ((item.kind == sfc_pkg::KIND_RELEASE) ? (byte_count_r != 8'd0)
                                                                 : (count_seen >= LAST_COUNT));
  assign byte_count_nxt = finish ? 8'd0 : count_seen;

  // Verdict: header/length check wins over the CRC check
  always_comb begin
    if (header_nxt != sfc_pkg::HEADER_VALUE || count_seen < sfc_pkg::MIN_FRAME) begin
      res.status = sfc_pkg::STATUS_BAD_HDR;
    end else if (crc_before_last_nxt != last_byte_nxt) begin
      res.status = sfc_pkg::STATUS_BAD_CRC;
    end else begin
      res.status = sfc_pkg::STATUS_OK;
    end
    res.first_byte   = header_nxt;
    res.command      = command_nxt;
    res.arg_one      = arg_one_nxt;
    res.arg_two      = arg_two_nxt;
    res.frame_length = count_seen;
  end

  assign res_valid = finish;

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r      <= 8'd0;
      crc_running_r     <= sfc_pkg::CRC_INIT;
      crc_before_last_r <= sfc_pkg::CRC_INIT;
      last_byte_r       <= 8'd0;
      header_r          <= 8'd0;
      command_r         <= 8'd0;
      arg_one_r         <= 8'd0;
      arg_two_r         <= 8'd0;
    end else begin
      byte_count_r      <= byte_count_nxt;
      crc_running_r     <= crc_running_nxt;
      crc_before_last_r <= crc_before_last_nxt;
      last_byte_r       <= last_byte_nxt;
      header_r          <= header_nxt;
      command_r         <= command_nxt;
      arg_one_r         <= arg_one_nxt;
      arg_two_r         <= arg_two_nxt;
    end
  end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the SPI command frame checker: random frames, stalls, CRC checks.
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAME_BYTES  = 32;
  localparam int RESET_CYCLES = 7;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 16;
  localparam int PRINT_LIMIT  = 50;
  // Shift-right form of the 0x18 feedback with the top-bit fill folded in
  localparam logic [7:0] CRC_FEEDBACK = 8'h8C;

  typedef enum int {STYLE_GOOD, STYLE_BAD_CRC, STYLE_BAD_HDR} frame_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Testbench-side drive of the channels
  logic       src_valid = 1'b0;
  logic       src_kind = sfc_pkg::KIND_DATA;
  logic [7:0] src_data = 8'h00;
  logic       sink_ready = 1'b0;

  sfc_in_if  in_if();
  sfc_out_if out_if();

  assign in_if.valid     = src_valid;
  assign in_if.kind      = src_kind;
  assign in_if.data_byte = src_data;
  assign out_if.ready    = sink_ready;

  spi_frame_crc8_checker #(
    .FRAME_BUFFER_BYTES(FRAME_BYTES)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  sfc_pkg::sfc_item_t   pending_beats[$];
  sfc_pkg::sfc_result_t expected_verdicts[$];

  int mismatch_count = 0;
  int beats_taken = 0;
  int idle_cycles = 0;
  logic in_taken = 1'b0;
  logic hold_req = 1'b0;

  // Frame tracker state
  int         fr_count = 0;
  logic [7:0] crc_all = sfc_pkg::CRC_INIT;
  logic [7:0] crc_prev = sfc_pkg::CRC_INIT;
  logic [7:0] fr_last = 8'h00;
  logic [7:0] fr_hdr = 8'h00;
  logic [7:0] fr_cmd = 8'h00;
  logic [7:0] fr_a1 = 8'h00;
  logic [7:0] fr_a2 = 8'h00;

  // Sender and receiver pacing
  int src_gap = 0;
  int src_calm = 0;
  int sink_stall = 0;
  int sink_calm = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Reflected CRC-8, LSB first
  function automatic logic [7:0] crc8_next(input logic [7:0] b, input logic [7:0] crc);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ b[0];
      crc = crc >> 1;
      b   = b >> 1;
      if (fb) crc = crc ^ CRC_FEEDBACK;
    end
    return crc;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_LIMIT)
      $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Verdict for the frame in progress, then start over
  task automatic close_frame();
    sfc_pkg::sfc_result_t v;
    if (fr_hdr != sfc_pkg::HEADER_VALUE || fr_count < int'(sfc_pkg::MIN_FRAME))
      v.status = sfc_pkg::STATUS_BAD_HDR;
    else if (crc_prev != fr_last)
      v.status = sfc_pkg::STATUS_BAD_CRC;
    else
      v.status = sfc_pkg::STATUS_OK;
    v.first_byte   = fr_hdr;
    v.command      = fr_cmd;
    v.arg_one      = fr_a1;
    v.arg_two      = fr_a2;
    v.frame_length = fr_count[7:0];
    expected_verdicts.push_back(v);
    fr_count = 0;
  endtask

  // Advance the frame tracker by one accepted beat
  task automatic take_beat(input logic kind, input logic [7:0] data);
    if (kind == sfc_pkg::KIND_RELEASE) begin
      // release on an empty frame gives nothing
      if (fr_count != 0) close_frame();
    end else begin
      if (fr_count == 0) begin
        crc_all = sfc_pkg::CRC_INIT;
        fr_hdr  = data;
        fr_cmd  = 8'h00;
        fr_a1   = 8'h00;
        fr_a2   = 8'h00;
      end else if (fr_count == 1) begin
        fr_cmd = data;
      end else if (fr_count == 2) begin
        fr_a1 = data;
      end else if (fr_count == 3) begin
        fr_a2 = data;
      end
      crc_prev = crc_all;
      crc_all  = crc8_next(data, crc_all);
      fr_last  = data;
      fr_count++;
      // buffer full ends the frame on this byte
      if (fr_count >= FRAME_BYTES - 1) close_frame();
    end
  endtask

  task automatic check_verdict();
    sfc_pkg::sfc_result_t want;
    if (expected_verdicts.size() == 0) begin
      flag_mismatch("unexpected verdict", out_if.status, 0);
    end else begin
      want = expected_verdicts.pop_front();
      if (out_if.status != want.status)
        flag_mismatch("status", out_if.status, want.status);
      if (out_if.first_byte != want.first_byte)
        flag_mismatch("first_byte", out_if.first_byte, want.first_byte);
      if (out_if.command != want.command)
        flag_mismatch("command", out_if.command, want.command);
      if (out_if.arg_one != want.arg_one)
        flag_mismatch("arg_one", out_if.arg_one, want.arg_one);
      if (out_if.arg_two != want.arg_two)
        flag_mismatch("arg_two", out_if.arg_two, want.arg_two);
      if (out_if.frame_length != want.frame_length)
        flag_mismatch("frame_length", out_if.frame_length, want.frame_length);
    end
  endtask

  task automatic push_beat(input logic kind, input logic [7:0] data);
    sfc_pkg::sfc_item_t it;
    it.kind      = kind;
    it.data_byte = data;
    pending_beats.push_back(it);
  endtask

  // One frame of len bytes followed by a select release
  task automatic queue_frame(input frame_style_t style, input int len);
    logic [7:0] crc;
    logic [7:0] b;
    crc = sfc_pkg::CRC_INIT;
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        b = sfc_pkg::HEADER_VALUE;
        if (style == STYLE_BAD_HDR) begin
          b = 8'($urandom_range(0, 255));
          while (b == sfc_pkg::HEADER_VALUE) b = 8'($urandom_range(0, 255));
        end
      end else if (i == len - 1) begin
        b = crc;
        if (style == STYLE_BAD_CRC) b = crc ^ 8'($urandom_range(1, 255));
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      crc = crc8_next(b, crc);
      push_beat(sfc_pkg::KIND_DATA, b);
    end
    push_beat(sfc_pkg::KIND_RELEASE, 8'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed frames, some broken ones and loose noise
  task automatic queue_random(input int beats);
    int start;
    int r;
    int n;
    start = pending_beats.size();
    while (pending_beats.size() - start < beats) begin
      r = $urandom_range(0, 99);
      if (r < 55)
        queue_frame(STYLE_GOOD, ($urandom_range(0, 9) == 0) ? $urandom_range(3, 30)
                                                              : $urandom_range(3, 10));
      else if (r < 70)
        queue_frame(STYLE_BAD_CRC, $urandom_range(3, 12));
      else if (r < 78)
        queue_frame(STYLE_BAD_HDR, $urandom_range(1, 12));
      else if (r < 86)
        queue_frame(STYLE_GOOD, $urandom_range(1, 2));
      else if (r < 94)
        queue_frame(STYLE_GOOD, $urandom_range(FRAME_BYTES - 3, FRAME_BYTES + 8));
      else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          push_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || src_valid || expected_verdicts.size() != 0)
      @(posedge clk);
  endtask

  // Sender: holds a beat until taken, then a gap or the next beat
  always @(negedge clk) begin
    if (!rst_n) begin
      src_valid <= 1'b0;
    end else if (src_valid && !in_taken) begin
      // beat still offered
    end else if (src_gap > 0) begin
      src_valid <= 1'b0;
      src_gap--;
    end else if (pending_beats.size() != 0) begin
      src_valid <= 1'b1;
      src_kind  <= pending_beats[0].kind;
      src_data  <= pending_beats[0].data_byte;
      void'(pending_beats.pop_front());
      if (src_calm > 0) begin
        src_calm--;
        src_gap = 0;
      end else begin
        src_gap = pick_gap();
        if ($urandom_range(0, 99) == 0) src_calm = $urandom_range(40, 120);
      end
    end else begin
      src_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else if (hold_left > 0) begin
      sink_ready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      sink_ready <= 1'b0;
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end else if (sink_stall > 0) begin
      sink_ready <= 1'b0;
      sink_stall--;
    end else begin
      sink_ready <= 1'b1;
      if (sink_calm > 0) begin
        sink_calm--;
      end else begin
        sink_stall = pick_gap();
        if ($urandom_range(0, 99) == 0) sink_calm = $urandom_range(40, 120);
      end
    end
  end

  // Monitor: tracks accepted beats, checks verdicts, watches for a hang
  always @(posedge clk) begin
    in_taken <= rst_n && in_if.valid && in_if.ready;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        beats_taken++;
        take_beat(in_if.kind, in_if.data_byte);
      end
      if (out_if.valid && out_if.ready) check_verdict();
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TIMEOUT after %0d idle cycles", idle_cycles);
        $display("spi_frame_crc8_checker verification failed");
        $finish;
      end
    end
  end

  // Stimulus sequence
  initial begin
    int mark;
    // directed part
    push_beat(sfc_pkg::KIND_RELEASE, 8'hFF);        // release on an empty frame
    push_beat(sfc_pkg::KIND_DATA, 8'hFF);           // one byte, wrong header
    push_beat(sfc_pkg::KIND_RELEASE, 8'h00);
    push_beat(sfc_pkg::KIND_DATA, sfc_pkg::HEADER_VALUE);   // good header but too short
    push_beat(sfc_pkg::KIND_DATA, 8'h00);
    push_beat(sfc_pkg::KIND_RELEASE, 8'hFF);
    push_beat(sfc_pkg::KIND_DATA, sfc_pkg::HEADER_VALUE);   // good four-byte frame
    push_beat(sfc_pkg::KIND_DATA, 8'h00);
    push_beat(sfc_pkg::KIND_DATA, 8'hFF);
    push_beat(sfc_pkg::KIND_DATA, crc8_next(8'hFF, crc8_next(8'h00,
              crc8_next(sfc_pkg::HEADER_VALUE, sfc_pkg::CRC_INIT))));
    push_beat(sfc_pkg::KIND_RELEASE, 8'h55);
    push_beat(sfc_pkg::KIND_DATA, sfc_pkg::HEADER_VALUE);   // CRC mismatch, all args present
    push_beat(sfc_pkg::KIND_DATA, 8'hFF);
    push_beat(sfc_pkg::KIND_DATA, 8'h00);
    push_beat(sfc_pkg::KIND_DATA, 8'h55);
    push_beat(sfc_pkg::KIND_DATA, crc8_next(8'h55, crc8_next(8'h00, crc8_next(8'hFF,
              crc8_next(sfc_pkg::HEADER_VALUE, sfc_pkg::CRC_INIT)))) ^ 8'h01);
    push_beat(sfc_pkg::KIND_RELEASE, 8'hAA);
    push_beat(sfc_pkg::KIND_DATA, 8'h00);           // bad header wins over a valid CRC
    push_beat(sfc_pkg::KIND_DATA, 8'h01);
    push_beat(sfc_pkg::KIND_DATA, crc8_next(8'h01, crc8_next(8'h00, sfc_pkg::CRC_INIT)));
    push_beat(sfc_pkg::KIND_RELEASE, 8'h00);
    push_beat(sfc_pkg::KIND_RELEASE, 8'hFF);        // second release, frame empty

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sender pauses until every verdict is in
    wait_drained();

    // random part, first half; starts with a frame that fills the buffer
    queue_frame(STYLE_GOOD, FRAME_BYTES - 1);
    queue_random(720);
    mark = beats_taken;
    while (beats_taken < mark + 150) @(posedge clk);
    hold_req = 1'b1;
    wait_drained();

    // random part, second half
    queue_random(780);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_verdicts.size() == 0)
      $display("spi_frame_crc8_checker verification clean");
    else
      $display("spi_frame_crc8_checker verification failed");
    $finish;
  end

endmodule

FILE: spi_frame_crc8_checker.f
design/sfc_pkg.sv
design/sfc_in_if.sv
design/sfc_out_if.sv
design/sfc_frame_core.sv
design/spi_frame_crc8_checker.sv
tb/tb_top.sv
